// File: sv/mtes_pkg.sv
package mtes_pkg;

    // Input operation codes.
    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_END   = 1'b1
    } t_op;

    // Widths of the fixed input and output fields.
    localparam int TICK_W    = 28;
    localparam int LEN_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int TLEN_W    = 32;

    // Number of event byte fields on the input channel.
    localparam int EVENT_FIELDS = 7;

    // A delta time is coded in at most four 7-bit groups.
    localparam int VLQ_BYTES = 4;
    localparam int VLQ_GRP_W = 7;

    // Byte constants of the track chunk.
    localparam logic [BYTE_W-1:0] VLQ_MORE      = 8'h80;
    localparam logic [BYTE_W-1:0] META_STATUS   = 8'hFF;
    localparam logic [BYTE_W-1:0] META_EOT_TYPE = 8'h2F;
    localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

    // End of track is always four bytes long.
    localparam int EOT_BYTES = 4;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// File: sv/mtes_encoder.sv
module mtes_encoder
    import mtes_pkg::*;
#(
    parameter int MAX_EVENT_BYTES = 7,
    parameter int FRAME_BYTES     = 11,
    parameter int CNT_W           = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [TICK_W-1:0] i_event_tick,
    input  logic [LEN_W-1:0]  i_event_length,
    input  t_byte             i_ev_bytes [EVENT_FIELDS],
    output logic              o_frame_valid,
    input  logic              i_frame_take,
    output t_byte             o_frame_bytes [FRAME_BYTES],
    output logic [CNT_W-1:0]  o_frame_cnt,
    output logic [TLEN_W-1:0] o_frame_tlen
);

    logic [TICK_W-1:0] r_prev_tick;
    logic [TLEN_W-1:0] r_count;
    logic              r_valid;
    t_byte             r_bytes [FRAME_BYTES];
    logic [CNT_W-1:0]  r_cnt;
    logic [TLEN_W-1:0] r_tlen;

    logic              accept;
    logic [TICK_W-1:0] delta;
    logic [1:0]        groups_m1;
    logic [LEN_W-1:0]  len;
    t_byte             vlq [VLQ_BYTES];
    t_byte             n_bytes [FRAME_BYTES];
    logic [CNT_W-1:0]  n_cnt;
    logic [TLEN_W-1:0] n_tlen;
    logic              is_end;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_frame_take;
    assign is_end  = (i_op == OP_END);

    // Saturating delta and number of 7-bit groups needed to code it.
    always_comb begin
        delta = (i_event_tick >= r_prev_tick) ? (i_event_tick - r_prev_tick) : '0;
        if (delta[27:21] != '0) begin
            groups_m1 = 2'd3;
        end else if (delta[20:14] != '0) begin
            groups_m1 = 2'd2;
        end else if (delta[13:7] != '0) begin
            groups_m1 = 2'd1;
        end else begin
            groups_m1 = 2'd0;
        end
    end

    always_comb begin
        if (i_event_length == '0) begin
            len = LEN_W'(1);
        end else if (i_event_length > LEN_W'(MAX_EVENT_BYTES)) begin
            len = LEN_W'(MAX_EVENT_BYTES);
        end else begin
            len = i_event_length;
        end
    end

    // Most significant group goes first; all but the final group carry the
    // continuation bit.
    always_comb begin
        logic [1:0] gi;
        for (int j = 0; j < VLQ_BYTES; j++) begin
            gi     = groups_m1 - 2'(j);
            vlq[j] = {1'b0, delta[VLQ_GRP_W*gi +: VLQ_GRP_W]};
            if (2'(j) != groups_m1) begin
                vlq[j] = vlq[j] | VLQ_MORE;
            end
        end
    end

    // Assemble the whole byte frame for this transaction.
    always_comb begin
        logic [3:0] eidx;
        for (int p = 0; p < FRAME_BYTES; p++) begin
            n_bytes[p] = ZERO_BYTE;
            eidx       = 4'(p) - {2'b00, groups_m1} - 4'd1;
            if (is_end) begin
                if (p == 1) begin
                    n_bytes[p] = META_STATUS;
                end else if (p == 2) begin
                    n_bytes[p] = META_EOT_TYPE;
                end
            end else if (p < VLQ_BYTES && 2'(p) <= groups_m1) begin
                n_bytes[p] = vlq[p % VLQ_BYTES];
            end else if (eidx < 4'(EVENT_FIELDS)) begin
                n_bytes[p] = i_ev_bytes[eidx[2:0]];
            end
        end
        if (is_end) begin
            n_cnt  = CNT_W'(EOT_BYTES);
            n_tlen = r_count + TLEN_W'(EOT_BYTES);
        end else begin
            n_cnt  = CNT_W'(groups_m1) + CNT_W'(1) + CNT_W'(len);
            n_tlen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tick <= '0;
            r_count     <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                if (is_end) begin
                    r_prev_tick <= '0;
                    r_count     <= '0;
                end else begin
                    r_prev_tick <= i_event_tick;
                    r_count     <= r_count + TLEN_W'(n_cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= n_bytes;
            r_cnt   <= n_cnt;
            r_tlen  <= n_tlen;
        end
    end

    assign o_frame_valid = r_valid;
    assign o_frame_bytes = r_bytes;
    assign o_frame_cnt   = r_cnt;
    assign o_frame_tlen  = r_tlen;

`ifndef SYNTHESIS
    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_end |=> r_count == '0 && r_prev_tick == '0)
        else $error("end of track did not clear the track state");

    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_frame_take |=> r_valid && $stable(r_cnt))
        else $error("pending frame lost before it was taken");
`endif

endmodule

// File: sv/mtes_shifter.sv
module mtes_shifter
    import mtes_pkg::*;
#(
    parameter int FRAME_BYTES = 11,
    parameter int CNT_W       = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_valid,
    output logic              o_frame_take,
    input  t_byte             i_frame_bytes [FRAME_BYTES],
    input  logic [CNT_W-1:0]  i_frame_cnt,
    input  logic [TLEN_W-1:0] i_frame_tlen,
    output logic              o_valid,
    input  logic              i_ready,
    output t_byte             o_out_byte,
    output logic              o_last,
    output logic [TLEN_W-1:0] o_track_length
);

    localparam int IDX_W = $clog2(FRAME_BYTES);

    t_byte             r_buf [FRAME_BYTES];
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic [TLEN_W-1:0] r_tlen;
    logic              r_busy;
    logic              r_out_valid;
    t_byte             r_out_byte;
    logic              r_out_last;
    logic [TLEN_W-1:0] r_out_tlen;

    logic advance;
    logic buf_last;
    logic buf_free;

    assign advance      = !r_out_valid || i_ready;
    assign buf_last     = (CNT_W'(r_idx) + CNT_W'(1) == r_cnt);
    assign buf_free     = !r_busy || (advance && buf_last);
    assign o_frame_take = i_frame_valid && buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (o_frame_take) begin
                r_busy <= 1'b1;
            end else if (advance && buf_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out_byte <= r_buf[r_idx];
            r_out_last <= buf_last;
            r_out_tlen <= buf_last ? r_tlen : '0;
        end
        if (o_frame_take) begin
            r_buf  <= i_frame_bytes;
            r_cnt  <= i_frame_cnt;
            r_tlen <= i_frame_tlen;
            r_idx  <= '0;
        end else if (advance && r_busy) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last         = r_out_last;
    assign o_track_length = r_out_tlen;

`ifndef SYNTHESIS
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> CNT_W'(r_idx) < r_cnt)
        else $error("byte index ran past the end of the frame");

    a_length_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tlen != '0 |-> r_out_last)
        else $error("track length shown on a byte that is not the last");
`endif

endmodule

// File: sv/midi_track_event_serializer_unit.sv
// Track chunk serializer for a Standard MIDI File.
// Input channel (i_valid / o_ready): one transaction is either a timed event
// (absolute tick plus one to seven event bytes) or an end-of-track request.
// Output channel (o_valid / i_ready): one transaction per track data byte.
// An event produces its tick delta as a variable-length quantity of one to
// four bytes followed by its event bytes; o_last marks the final byte.
// End of track produces 00 FF 2F 00, shows the total track length on the
// final byte, and clears the previous tick and the byte count.
// An accepted transaction moves from the frame register to the frame buffer
// and leaves byte by byte through the output register. The output runs at
// one byte per cycle without gaps while i_ready is high and frames wait; a
// transaction is two to eleven bytes for an event, four for end of track;
// the single output byte port sets that rate. A frame register and a frame
// buffer let the next transaction be accepted while the current one goes out.
// Reset (synchronous, active low) clears the previous tick, the byte count
// and all valid flags. When the receiver stalls, the output byte holds and
// the frame buffer and frame register fill, after which o_ready drops.
module midi_track_event_serializer_unit
    import mtes_pkg::*;
#(
    parameter int MAX_EVENT_BYTES = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [TICK_W-1:0] i_event_tick,
    input  logic [LEN_W-1:0]  i_event_length,
    input  logic [BYTE_W-1:0] i_byte_a,
    input  logic [BYTE_W-1:0] i_byte_b,
    input  logic [BYTE_W-1:0] i_byte_c,
    input  logic [BYTE_W-1:0] i_byte_d,
    input  logic [BYTE_W-1:0] i_byte_e,
    input  logic [BYTE_W-1:0] i_byte_f,
    input  logic [BYTE_W-1:0] i_byte_g,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last,
    output logic [TLEN_W-1:0] o_track_length
);

    // A frame holds the longest delta code plus the largest event.
    localparam int FRAME_BYTES = VLQ_BYTES + MAX_EVENT_BYTES;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    t_byte             ev_bytes [EVENT_FIELDS];
    logic              frame_valid;
    logic              frame_take;
    t_byte             frame_bytes [FRAME_BYTES];
    logic [CNT_W-1:0]  frame_cnt;
    logic [TLEN_W-1:0] frame_tlen;

    // Event bytes in transmit order.
    assign ev_bytes[0] = i_byte_a;
    assign ev_bytes[1] = i_byte_b;
    assign ev_bytes[2] = i_byte_c;
    assign ev_bytes[3] = i_byte_d;
    assign ev_bytes[4] = i_byte_e;
    assign ev_bytes[5] = i_byte_f;
    assign ev_bytes[6] = i_byte_g;

    // The encoder computes the delta and the complete byte frame of a
    // transaction in one pass and keeps the running tick and byte count.
    mtes_encoder #(
        .MAX_EVENT_BYTES (MAX_EVENT_BYTES),
        .FRAME_BYTES     (FRAME_BYTES),
        .CNT_W           (CNT_W)
    ) u_encoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_event_tick   (i_event_tick),
        .i_event_length (i_event_length),
        .i_ev_bytes     (ev_bytes),
        .o_frame_valid  (frame_valid),
        .i_frame_take   (frame_take),
        .o_frame_bytes  (frame_bytes),
        .o_frame_cnt    (frame_cnt),
        .o_frame_tlen   (frame_tlen)
    );

    // The shifter feeds the output register one byte per cycle unless stalled.
    mtes_shifter #(
        .FRAME_BYTES (FRAME_BYTES),
        .CNT_W       (CNT_W)
    ) u_shifter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_valid  (frame_valid),
        .o_frame_take   (frame_take),
        .i_frame_bytes  (frame_bytes),
        .i_frame_cnt    (frame_cnt),
        .i_frame_tlen   (frame_tlen),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_track_length (o_track_length)
    );

endmodule
